// ===== sv/lhp_pkg.sv =====
// lhp_pkg: shared types, command codes, widths and states for the latency histogram core
// depends on nothing; used by lhp_ctrl, lhp_dpath and latency_histogram_percentile_core
`timescale 1ns / 1ps

package lhp_pkg;

	localparam int BUCKETS_DEF = 1024;

	// fraction scale: 10000 is one whole
	localparam int FRAC_W = 14;
	localparam logic [FRAC_W-1:0] FRAC_ONE = 14'd10000;

	// 32-bit count or bucket times a 14-bit fraction or scale
	localparam int PROD_W = 32 + FRAC_W;

	localparam int PB_W = 11;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [31:0]       latency_value;
		logic [FRAC_W-1:0] fraction;
	} hist_cmd_t;

	typedef struct packed {
		logic [PB_W-1:0] percentile_bucket;
		logic [31:0]     peak_latency;
		logic [31:0]     sample_count;
		logic [63:0]     latency_sum;
		logic [31:0]     overflow_count;
	} hist_res_t;

	typedef enum logic [2:0] {
		ST_SWEEP_RST,
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_SWEEP_CLR,
		ST_Q_MUL,
		ST_Q_WALK,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic add_rd;
		logic add_wr;
		logic clr_tot;
		logic sweep_en;
		logic walk_init;
		logic walk_en;
		logic ld_out;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_last;
		logic count_zero;
		logic walk_done;
		logic out_busy;
	} sts_t;

endpackage

// ===== sv/lhp_ctrl.sv =====
// lhp_ctrl: sequencing state machine for add, clear, query and the clearing sweep
// depends on lhp_pkg
`timescale 1ns / 1ps

module lhp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  logic [1:0]      command,
	output logic            cmd_stall,
	output lhp_pkg::ctl_t   ctl,
	input  lhp_pkg::sts_t   sts
);

	lhp_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lhp_pkg::ST_SWEEP_RST;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lhp_pkg::ST_SWEEP_RST: begin
				if (sts.sweep_last) begin
					state_nx = lhp_pkg::ST_IDLE;
				end
			end
			lhp_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					unique case (command)
						lhp_pkg::CMD_ADD:   state_nx = lhp_pkg::ST_ADD_RD;
						lhp_pkg::CMD_CLEAR: state_nx = lhp_pkg::ST_SWEEP_CLR;
						lhp_pkg::CMD_QUERY: state_nx = lhp_pkg::ST_Q_MUL;
						default:            state_nx = lhp_pkg::ST_FINISH;
					endcase
				end
			end
			lhp_pkg::ST_ADD_RD: begin
				state_nx = lhp_pkg::ST_ADD_WR;
			end
			lhp_pkg::ST_ADD_WR: begin
				state_nx = sts.out_busy ? lhp_pkg::ST_FINISH : lhp_pkg::ST_IDLE;
			end
			lhp_pkg::ST_SWEEP_CLR: begin
				if (sts.sweep_last) begin
					state_nx = lhp_pkg::ST_FINISH;
				end
			end
			lhp_pkg::ST_Q_MUL: begin
				state_nx = sts.count_zero ? lhp_pkg::ST_FINISH : lhp_pkg::ST_Q_WALK;
			end
			lhp_pkg::ST_Q_WALK: begin
				if (sts.walk_done) begin
					state_nx = lhp_pkg::ST_FINISH;
				end
			end
			lhp_pkg::ST_FINISH: begin
				if (!sts.out_busy) begin
					state_nx = lhp_pkg::ST_IDLE;
				end
			end
			default: state_nx = lhp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		cmd_stall = 1'b1;
		unique case (state_q)
			lhp_pkg::ST_SWEEP_RST: begin
				ctl.sweep_en = 1'b1;
			end
			lhp_pkg::ST_IDLE: begin
				cmd_stall   = 1'b0;
				ctl.load_in = cmd_valid;
			end
			lhp_pkg::ST_ADD_RD: begin
				ctl.add_rd = 1'b1;
			end
			lhp_pkg::ST_ADD_WR: begin
				ctl.add_wr = 1'b1;
				ctl.ld_out = !sts.out_busy;
			end
			lhp_pkg::ST_SWEEP_CLR: begin
				ctl.sweep_en = 1'b1;
				ctl.clr_tot  = 1'b1;
			end
			lhp_pkg::ST_Q_MUL: begin
				ctl.walk_init = 1'b1;
			end
			lhp_pkg::ST_Q_WALK: begin
				ctl.walk_en = 1'b1;
			end
			lhp_pkg::ST_FINISH: begin
				ctl.ld_out = !sts.out_busy;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

// ===== sv/lhp_dpath.sv =====
// lhp_dpath: bucket memory, running totals, percentile walk pipeline and result register
// depends on lhp_pkg
`timescale 1ns / 1ps

module lhp_dpath #(
	parameter int BUCKETS = lhp_pkg::BUCKETS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lhp_pkg::hist_cmd_t  cmd_word,
	input  lhp_pkg::ctl_t       ctl,
	output lhp_pkg::sts_t       sts,
	output logic                res_valid,
	input  logic                res_stall,
	output lhp_pkg::hist_res_t  res_word
);

	localparam int IW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	// scaled running sum: bucket sum times the fraction scale
	localparam int AW = IW + lhp_pkg::PROD_W;
	localparam logic [IW:0] BUCKETS_W = (IW + 1)'(BUCKETS);
	localparam logic [IW:0] LAST_W    = (IW + 1)'(BUCKETS - 1);

	logic [31:0] mem [BUCKETS];

	lhp_pkg::hist_cmd_t item_q;
	logic [IW:0]        cnt_q;
	logic [31:0]        rd_s1;
	logic               v_s1, v_s2;
	logic [IW-1:0]      idx_s1, idx_s2;
	logic [lhp_pkg::PROD_W-1:0] prod_s2;
	logic [lhp_pkg::PROD_W-1:0] rank_q;
	logic [AW-1:0]      acc_q;
	logic               found_q;
	logic [IW-1:0]      pb_q;

	logic [31:0] peak_q, count_q, ovf_q;
	logic [63:0] sum_q;

	logic               out_valid_q;
	lhp_pkg::hist_res_t res_q;

	logic                      in_range;
	logic [IW-1:0]             val_idx;
	logic                      mem_we;
	logic [IW-1:0]             mem_waddr, mem_raddr;
	logic [31:0]               mem_wdata;
	logic [64:0]               sum_wide;
	logic [lhp_pkg::FRAC_W-1:0] frac_sat;
	logic                      issue;
	logic [AW-1:0]             acc_nx;
	logic                      hit;
	logic                      cnt_left;
	logic [IW:0]               pb_full;
	logic [31:0]               pb_wide;
	lhp_pkg::hist_res_t        res_nx;

	assign in_range = item_q.latency_value < 32'(BUCKETS);
	assign val_idx  = item_q.latency_value[IW-1:0];
	assign cnt_left = cnt_q < BUCKETS_W;

	// single write port: sweep or add write-back
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[IW-1:0];
		mem_wdata = '0;
		if (ctl.sweep_en) begin
			mem_we = 1'b1;
		end else if (ctl.add_wr && in_range) begin
			mem_we    = 1'b1;
			mem_waddr = val_idx;
			mem_wdata = (rd_s1 == '1) ? rd_s1 : rd_s1 + 32'd1;
		end
	end

	assign mem_raddr = ctl.add_rd ? val_idx : cnt_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_s1 <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			item_q <= cmd_word;
		end
	end

	// totals
	assign sum_wide = 65'(sum_q) + 65'(item_q.latency_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= '0;
			count_q <= '0;
			ovf_q   <= '0;
			sum_q   <= '0;
		end else if (ctl.clr_tot) begin
			peak_q  <= '0;
			count_q <= '0;
			ovf_q   <= '0;
			sum_q   <= '0;
		end else if (ctl.add_rd) begin
			if (count_q != '1) begin
				count_q <= count_q + 32'd1;
			end
			sum_q <= sum_wide[64] ? '1 : sum_wide[63:0];
			if (item_q.latency_value > peak_q) begin
				peak_q <= item_q.latency_value;
			end
			if (!in_range && ovf_q != '1) begin
				ovf_q <= ovf_q + 32'd1;
			end
		end
	end

	// percentile walk: read, scale, accumulate and compare against count * fraction
	assign frac_sat = (item_q.fraction > lhp_pkg::FRAC_ONE) ? lhp_pkg::FRAC_ONE
		: item_q.fraction;
	assign acc_nx = acc_q + AW'(prod_s2);
	assign hit    = v_s2 && !found_q && (acc_nx >= AW'(rank_q)) && (acc_nx != '0);
	assign issue  = ctl.walk_en && !found_q && !hit && cnt_left;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (ctl.load_in) begin
				cnt_q <= '0;
			end else if (ctl.sweep_en || issue) begin
				cnt_q <= cnt_q + (IW + 1)'(1);
			end
			if (ctl.walk_init) begin
				v_s1    <= 1'b0;
				v_s2    <= 1'b0;
				found_q <= 1'b0;
			end else begin
				v_s1 <= issue;
				v_s2 <= v_s1;
				if (hit) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cnt_q[IW-1:0];
		idx_s2  <= idx_s1;
		prod_s2 <= lhp_pkg::PROD_W'(rd_s1) * lhp_pkg::PROD_W'(lhp_pkg::FRAC_ONE);
		if (ctl.walk_init) begin
			rank_q <= lhp_pkg::PROD_W'(count_q) * lhp_pkg::PROD_W'(frac_sat);
			acc_q  <= '0;
		end else if (v_s2) begin
			acc_q <= acc_nx;
		end
		if (hit) begin
			pb_q <= idx_s2;
		end
	end

	// result word
	always_comb begin
		pb_full = '0;
		if (item_q.command == lhp_pkg::CMD_QUERY && count_q != '0) begin
			pb_full = found_q ? {1'b0, pb_q} : BUCKETS_W;
		end
	end

	assign pb_wide = 32'(pb_full);

	always_comb begin
		res_nx.percentile_bucket = pb_wide[lhp_pkg::PB_W-1:0];
		res_nx.peak_latency      = peak_q;
		res_nx.sample_count      = count_q;
		res_nx.latency_sum       = sum_q;
		res_nx.overflow_count    = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			res_q <= res_nx;
		end
	end

	assign res_valid = out_valid_q;
	assign res_word  = res_q;

	assign sts.sweep_last = cnt_q == LAST_W;
	assign sts.count_zero = count_q == '0;
	assign sts.walk_done  = found_q || (!cnt_left && !v_s1 && !v_s2);
	assign sts.out_busy   = out_valid_q && res_stall;

endmodule

// ===== sv/latency_histogram_percentile_core.sv =====
// latency_histogram_percentile_core: top level of the latency histogram with percentile query
// depends on lhp_pkg, lhp_ctrl and lhp_dpath
`timescale 1ns / 1ps

// latency histogram: each command word adds a sample, clears everything, asks for a
// percentile or is otherwise ignored, and gives back exactly one result word carrying the
// percentile bucket (zero unless a query), the peak, the sample count, the saturating sum
// and the overflow count, all as they stand after the command. buckets live in a memory of
// BUCKETS entries of 32 bits with one write port, so the command port stalls while a word
// is being worked on. after reset the memory is cleared by a sweep over all BUCKETS
// entries before the first word is taken; a clear runs the same sweep. an add reads the
// bucket, then writes back the saturating increment. a query on an empty histogram skips
// the walk; otherwise the walk reads one bucket per cycle from the memory port, scales it
// by 10000 and compares the running total with count * fraction, so the rank is exact
// without any divider. a finished result waits in an output register; the next word is
// taken once the result is loaded there.

module latency_histogram_percentile_core #(
	parameter int BUCKETS = lhp_pkg::BUCKETS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  lhp_pkg::hist_cmd_t  cmd_word,
	output logic                res_valid,
	input  logic                res_stall,
	output lhp_pkg::hist_res_t  res_word
);

	lhp_pkg::ctl_t ctl;
	lhp_pkg::sts_t sts;

	// sequencing: one command word at a time
	lhp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (cmd_word.command),
		.cmd_stall (cmd_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	// memory, totals, walk pipeline and result register
	lhp_dpath #(
		.BUCKETS (BUCKETS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_word  (cmd_word),
		.ctl       (ctl),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule

// ===== tb/tb_latency_histogram_percentile_core.sv =====
// tb_latency_histogram_percentile_core: self-checking bench for the latency histogram core
// depends on lhp_pkg and latency_histogram_percentile_core; a local histogram predicts each word
`timescale 1ns / 1ps

module tb_latency_histogram_percentile_core;

	localparam int BUCKETS = lhp_pkg::BUCKETS_DEF;

	// command code the core must ignore apart from reporting the totals
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// longest stretch with no word moving on either port before the run is abandoned;
	// a clear or a full walk covers BUCKETS entries, so this leaves a wide margin
	localparam int IDLE_LIMIT = 20 * BUCKETS;

	// quiet time after the last result, longer than the slowest query or clear
	localparam int DRAIN_CYCLES = 2 * BUCKETS + 64;

	localparam int RANDOM_WORDS = 1330;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	lhp_pkg::hist_cmd_t cmd_word = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	lhp_pkg::hist_res_t res_word;

	latency_histogram_percentile_core #(
		.BUCKETS(BUCKETS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_word(cmd_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// local copy of the histogram, updated as each command word is taken
	// ------------------------------------------------------------------
	logic [31:0] hist_buckets [BUCKETS];
	logic [31:0] hist_overflow;
	logic [31:0] hist_samples;
	logic [63:0] hist_sum;
	logic [31:0] hist_peak;

	lhp_pkg::hist_cmd_t pending_cmds [$];
	lhp_pkg::hist_res_t expected_results [$];

	int mismatch_count = 0;
	int result_index = 0;

	function automatic void clear_histogram();
		for (int i = 0; i < BUCKETS; i++)
			hist_buckets[i] = '0;
		hist_overflow = '0;
		hist_samples = '0;
		hist_sum = '0;
		hist_peak = '0;
	endfunction

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	// apply one command word to the local histogram and give the result word it must produce
	function automatic lhp_pkg::hist_res_t predict_histogram(lhp_pkg::hist_cmd_t c);
		lhp_pkg::hist_res_t r;
		logic [64:0] wide_sum;
		logic [63:0] rank;
		logic [63:0] seen;
		logic [63:0] frac;
		logic [31:0] hit;
		logic        found;
		hit = 32'd0;
		case (c.command)
			lhp_pkg::CMD_ADD: begin
				hist_samples = sat_inc(hist_samples);
				wide_sum = {1'b0, hist_sum} + {33'd0, c.latency_value};
				hist_sum = wide_sum[64] ? '1 : wide_sum[63:0];
				if (c.latency_value > hist_peak)
					hist_peak = c.latency_value;
				if (c.latency_value < BUCKETS)
					hist_buckets[c.latency_value] = sat_inc(hist_buckets[c.latency_value]);
				else
					hist_overflow = sat_inc(hist_overflow);
			end
			lhp_pkg::CMD_CLEAR: begin
				clear_histogram();
			end
			lhp_pkg::CMD_QUERY: begin
				if (hist_samples != 0) begin
					// fraction saturates at one whole
					frac = (c.fraction > lhp_pkg::FRAC_ONE) ? 64'(lhp_pkg::FRAC_ONE)
						: 64'(c.fraction);
					rank = (64'(hist_samples) * frac + 64'(lhp_pkg::FRAC_ONE) - 64'd1)
						/ 64'(lhp_pkg::FRAC_ONE);
					if (rank == 0)
						rank = 64'd1;
					// rank never reached means every sample left is in overflow
					hit = BUCKETS;
					seen = '0;
					found = 1'b0;
					for (int i = 0; i < BUCKETS; i++) begin
						seen = seen + 64'(hist_buckets[i]);
						if (!found && seen >= rank) begin
							hit = i;
							found = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.percentile_bucket = hit[lhp_pkg::PB_W-1:0];
		r.peak_latency = hist_peak;
		r.sample_count = hist_samples;
		r.latency_sum = hist_sum;
		r.overflow_count = hist_overflow;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at result %0d: %s", result_index, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
	endtask

	// ------------------------------------------------------------------
	// stimulus builders
	// ------------------------------------------------------------------
	function automatic lhp_pkg::hist_cmd_t make_cmd(logic [1:0] command, logic [31:0] value,
			logic [lhp_pkg::FRAC_W-1:0] fraction);
		lhp_pkg::hist_cmd_t c;
		c.command = command;
		c.latency_value = value;
		c.fraction = fraction;
		return c;
	endfunction

	function automatic logic [lhp_pkg::FRAC_W-1:0] rand_fraction();
		return lhp_pkg::FRAC_W'($urandom_range(16383));
	endfunction

	// sample value; narrow mode keeps most samples in the first few buckets so queries stay short
	function automatic logic [31:0] pick_sample(bit narrow);
		int r;
		r = $urandom_range(99);
		if (narrow && r < 85)
			return $urandom_range(31);
		if (r < 70)
			return $urandom_range(BUCKETS - 1);
		if (r < 80)
			return BUCKETS + $urandom_range(3000);
		if (r < 90)
			return $urandom;
		case ($urandom_range(3))
			0: return 32'd0;
			1: return BUCKETS - 1;
			2: return BUCKETS;
			default: return '1;
		endcase
	endfunction

	function automatic logic [lhp_pkg::FRAC_W-1:0] pick_fraction();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 20)
			return lhp_pkg::FRAC_ONE;
		if (r < 30)
			return lhp_pkg::FRAC_W'($urandom_range((1 << lhp_pkg::FRAC_W) - 1,
				lhp_pkg::FRAC_ONE + 1));
		return lhp_pkg::FRAC_W'($urandom_range(lhp_pkg::FRAC_ONE));
	endfunction

	// ------------------------------------------------------------------
	// command driver: bursts of words with random gaps between them
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd_word <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (cmd_valid && cmd_stall) begin
			// word held until the core takes it
		end else if (gap_left > 0) begin
			cmd_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_cmds.size() > 0) begin
			cmd_valid <= 1'b1;
			cmd_word <= pending_cmds.pop_front();
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(40, 1);
				// about a third of the bursts run straight into the next one
				gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(20, 1);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			cmd_valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// result stall: random stalls, at a rate redrawn whenever a random hold count runs out
	// ------------------------------------------------------------------
	int stall_pct = 0;
	int stall_hold = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_pct <= 0;
			stall_hold <= 0;
		end else begin
			if (stall_hold == 0) begin
				stall_hold <= $urandom_range(400, 32);
				case ($urandom_range(3))
					0: stall_pct <= 0;
					1: stall_pct <= 30;
					2: stall_pct <= 60;
					default: stall_pct <= 90;
				endcase
			end else begin
				stall_hold <= stall_hold - 1;
			end
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// monitor: check each result word, then predict the word just taken
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		lhp_pkg::hist_res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result word with nothing outstanding");
				end else begin
					want = expected_results.pop_front();
					check_field("percentile_bucket", 64'(res_word.percentile_bucket),
						64'(want.percentile_bucket));
					check_field("peak_latency", 64'(res_word.peak_latency),
						64'(want.peak_latency));
					check_field("sample_count", 64'(res_word.sample_count),
						64'(want.sample_count));
					check_field("latency_sum", res_word.latency_sum, want.latency_sum);
					check_field("overflow_count", 64'(res_word.overflow_count),
						64'(want.overflow_count));
				end
				result_index++;
			end
			if (cmd_valid && !cmd_stall)
				expected_results.push_back(predict_histogram(cmd_word));
		end
	end

	// ------------------------------------------------------------------
	// watchdog on cycles in which no word moves
	// ------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
				$display("[latency_histogram_percentile_core] ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int  r;
		bit  narrow;
		clear_histogram();

		// directed: empty histogram, extreme samples, rank edges and the ignored code
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_QUERY, $urandom, 14'd5000));
		pending_cmds.push_back(make_cmd(CMD_UNUSED, $urandom, rand_fraction()));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_ADD, 32'd0, '1));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_QUERY, '1, '0));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_ADD, BUCKETS - 1, '0));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_ADD, BUCKETS, '0));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_ADD, '1, '0));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_ADD, '1, '1));
		// most samples in overflow: the top ranks are never reached
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_QUERY, '0, lhp_pkg::FRAC_ONE));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_QUERY, '0, '1));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_QUERY, '0, 14'd4000));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_QUERY, '0, 14'd2000));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_QUERY, '0, 14'd1));
		pending_cmds.push_back(make_cmd(CMD_UNUSED, '1, '1));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_CLEAR, $urandom, rand_fraction()));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_QUERY, '0, lhp_pkg::FRAC_ONE));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_ADD, 32'd5, '0));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_ADD, 32'd5, '0));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_ADD, 32'd7, '0));
		// exact rank either side of a whole number
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_QUERY, '0, 14'd6667));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_QUERY, '0, 14'd6666));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_ADD, 32'h8000_0000, '0));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_CLEAR, '1, '1));
		pending_cmds.push_back(make_cmd(lhp_pkg::CMD_ADD, 32'h5555_5555, 14'h2aaa));

		// random: mostly adds, queries now and then, rare clears and ignored codes;
		// sample spread is redrawn as narrow or wide every 150 words
		narrow = 1'b0;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 150 == 0)
				narrow = 1'($urandom_range(1));
			r = $urandom_range(99);
			if (r < 2)
				pending_cmds.push_back(make_cmd(lhp_pkg::CMD_CLEAR, $urandom,
					rand_fraction()));
			else if (r < 4)
				pending_cmds.push_back(make_cmd(CMD_UNUSED, $urandom, rand_fraction()));
			else if (r < 16)
				pending_cmds.push_back(make_cmd(lhp_pkg::CMD_QUERY, $urandom,
					pick_fraction()));
			else
				pending_cmds.push_back(make_cmd(lhp_pkg::CMD_ADD, pick_sample(narrow),
					rand_fraction()));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// all words taken and all results back, then a quiet spell for stray results
		while (pending_cmds.size() != 0 || cmd_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("[latency_histogram_percentile_core] OK");
		else
			$display("[latency_histogram_percentile_core] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/lhp_pkg.sv
sv/lhp_ctrl.sv
sv/lhp_dpath.sv
sv/latency_histogram_percentile_core.sv
tb/tb_latency_histogram_percentile_core.sv
